FILE: rtl/core/tsrp_pkg.sv
// Shared constants and default parameters for the triangular step-rate profile block.
`timescale 1ns / 1ps

package tsrp_pkg;

   // Default profile parameters
   localparam int MAX_SLICES_DEFAULT = 64;
   localparam int SLICE_MS_DEFAULT   = 10;

   // Port field widths
   localparam int STEPS_W    = 16;
   localparam int MS_W       = 16;
   localparam int IDX_W      = 6;
   localparam int RATE_W     = 16;
   localparam int POS_W      = 32;

   // Slice count holds 0..64
   localparam int CNT_W      = IDX_W + 1;

   // Shared divider: dividend holds 2000*32768 < 2^26, divisor holds the duration
   localparam int DIV_W      = 26;
   localparam int DEN_W      = 16;
   localparam int DIV_CNT_W  = $clog2(DIV_W + 1);

   // Scale for the peak rate and widths of the running sums
   localparam int PEAK_GAIN  = 2000;
   localparam int GAIN_W     = 11;
   localparam int TARGET_W   = 25;
   localparam int SUM_W      = 22;

endpackage

FILE: rtl/core/triangular_step_rate_profile.sv
// Top level of the triangular step-rate profile generator with a shared iterative divider.
//
//   channel | direction | handshake             | payload
//   req     | in        | req_valid / req_ready | steps_to_move, duration_ms
//   rsp     | out       | rsp_valid / rsp_ready | slice_index, step_rate, direction,
//           |           |                       | target_steps, position, bad_duration, last
//
// One restoring divider, which produces one quotient bit per cycle, runs up to four
// divisions per command: slice count, peak rate, slope and the shortfall share.
// A good command with S slices runs its divisions and a sum over the S slices before its
// first item, then gives one item per slice; a bad duration gives its single item after the first division.
// A zero step count is accepted and gives no item.
// req_ready is high only while idle; a stalled rsp item holds the block.
// Reset (synchronous, active high) clears the sequencer and the running position.
`timescale 1ns / 1ps

module triangular_step_rate_profile
   import tsrp_pkg::*;
#(
   parameter int MAX_SLICES = MAX_SLICES_DEFAULT,
   parameter int SLICE_MS   = SLICE_MS_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic signed [STEPS_W-1:0] req_steps_to_move,
   input  logic        [MS_W-1:0]    req_duration_ms,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic        [IDX_W-1:0]   rsp_slice_index,
   output logic        [RATE_W-1:0]  rsp_step_rate,
   output logic                      rsp_direction,
   output logic        [STEPS_W-1:0] rsp_target_steps,
   output logic signed [POS_W-1:0]   rsp_position,
   output logic                      rsp_bad_duration,
   output logic                      rsp_last
);

   // Slices per second, used to scale the target sum
   localparam int SCALE_K = 1000 / SLICE_MS;

   typedef enum logic [5:0] {
      S_IDLE   = 6'b000001,
      S_DIVIDE = 6'b000010,
      S_SUM    = 6'b000100,
      S_SHARE  = 6'b001000,
      S_LOAD   = 6'b010000,
      S_OUTPUT = 6'b100000
   } state_type;

   typedef enum logic [3:0] {
      OP_SLICES = 4'b0001,
      OP_PEAK   = 4'b0010,
      OP_SLOPE  = 4'b0100,
      OP_SPREAD = 4'b1000
   } div_op_type;

   state_type               state_ff, state_in;
   div_op_type              op_ff, op_in;

   logic [DIV_W-1:0]        div_quo_ff, div_quo_in;
   logic [DEN_W-1:0]        div_rem_ff, div_rem_in;
   logic [DEN_W-1:0]        div_den_ff, div_den_in;
   logic [DIV_CNT_W-1:0]    div_cnt_ff, div_cnt_in;

   logic [STEPS_W-1:0]      mag_ff, mag_in;
   logic                    neg_ff, neg_in;
   logic signed [POS_W-1:0] pos_ff, pos_in;
   logic [MS_W-1:0]         ms_ff, ms_in;
   logic [CNT_W-1:0]        slices_ff, slices_in;
   logic [TARGET_W-1:0]     target_ff, target_in;
   logic [RATE_W-1:0]       slope_ff, slope_in;
   logic [SUM_W-1:0]        sum_ff, sum_in;
   logic [RATE_W-1:0]       share_q_ff, share_q_in;
   logic [IDX_W-1:0]        share_r_ff, share_r_in;
   logic [IDX_W-1:0]        idx_ff, idx_in;

   logic [IDX_W-1:0]        out_idx_ff, out_idx_in;
   logic [RATE_W-1:0]       out_rate_ff, out_rate_in;
   logic                    out_bad_ff, out_bad_in;
   logic                    out_last_ff, out_last_in;

   // Restoring divider step
   logic [DEN_W:0]          div_trial;
   logic                    div_fit;

   // Slice arithmetic
   logic [CNT_W-1:0]        idx_ext;
   logic [CNT_W-1:0]        mid;
   logic [CNT_W-1:0]        ramp_k;
   logic [RATE_W-1:0]       ramp_rate;
   logic                    idx_is_end;
   logic [STEPS_W-1:0]      req_mag;
   logic                    req_neg;
   logic [DIV_W-1:0]        peak_num;
   logic [DIV_W-1:0]        target_prod;
   logic                    slices_bad;

   assign div_trial = {div_rem_ff, div_quo_ff[DIV_W-1]};
   assign div_fit   = (div_trial >= {1'b0, div_den_ff});

   assign idx_ext    = {1'b0, idx_ff};
   assign mid        = slices_ff >> 1;
   assign ramp_k     = (idx_ext < mid) ? idx_ext : (slices_ff - idx_ext);
   assign ramp_rate  = slope_ff * RATE_W'(ramp_k);
   assign idx_is_end = ((idx_ext + CNT_W'(1)) == slices_ff);

   assign req_neg     = req_steps_to_move[STEPS_W-1];
   assign req_mag     = req_neg ? (STEPS_W'(0) - req_steps_to_move) : req_steps_to_move;
   assign peak_num    = DIV_W'(mag_ff) * DIV_W'(PEAK_GAIN);
   assign target_prod = DIV_W'(mag_ff) * DIV_W'(SCALE_K);
   assign slices_bad  = (div_quo_ff == '0) || (div_quo_ff > DIV_W'(MAX_SLICES));

   // Sequencer and datapath next values
   always_comb begin
      state_in    = state_ff;
      op_in       = op_ff;
      div_quo_in  = div_quo_ff;
      div_rem_in  = div_rem_ff;
      div_den_in  = div_den_ff;
      div_cnt_in  = div_cnt_ff;
      mag_in      = mag_ff;
      neg_in      = neg_ff;
      pos_in      = pos_ff;
      ms_in       = ms_ff;
      slices_in   = slices_ff;
      target_in   = target_ff;
      slope_in    = slope_ff;
      sum_in      = sum_ff;
      share_q_in  = share_q_ff;
      share_r_in  = share_r_ff;
      idx_in      = idx_ff;
      out_idx_in  = out_idx_ff;
      out_rate_in = out_rate_ff;
      out_bad_in  = out_bad_ff;
      out_last_in = out_last_ff;

      unique case (state_ff)
         S_IDLE: begin
            // Take a command; a zero count is dropped
            if (req_valid && (req_steps_to_move != '0)) begin
               mag_in     = req_mag;
               neg_in     = req_neg;
               pos_in     = pos_ff + POS_W'(req_steps_to_move);
               ms_in      = req_duration_ms;
               div_quo_in = DIV_W'(req_duration_ms);
               div_den_in = DEN_W'(SLICE_MS);
               div_rem_in = '0;
               div_cnt_in = DIV_CNT_W'(DIV_W);
               op_in      = OP_SLICES;
               state_in   = S_DIVIDE;
            end
         end

         S_DIVIDE: begin
            if (div_cnt_ff != '0) begin
               // Shift in one dividend bit and subtract when it fits
               div_rem_in = div_fit ? DEN_W'(div_trial - {1'b0, div_den_ff})
                                    : DEN_W'(div_trial);
               div_quo_in = {div_quo_ff[DIV_W-2:0], div_fit};
               div_cnt_in = div_cnt_ff - DIV_CNT_W'(1);
            end else begin
               // Dispatch on the finished quotient
               div_rem_in = '0;
               div_cnt_in = DIV_CNT_W'(DIV_W);
               unique case (op_ff)
                  OP_SLICES: begin
                     if (slices_bad) begin
                        out_idx_in  = '0;
                        out_rate_in = '0;
                        out_bad_in  = 1'b1;
                        out_last_in = 1'b1;
                        state_in    = S_OUTPUT;
                     end else begin
                        slices_in  = CNT_W'(div_quo_ff);
                        target_in  = TARGET_W'(target_prod);
                        div_quo_in = peak_num;
                        div_den_in = ms_ff;
                        op_in      = OP_PEAK;
                     end
                  end
                  OP_PEAK: begin
                     div_quo_in = div_quo_ff;
                     div_den_in = DEN_W'(slices_ff);
                     op_in      = OP_SLOPE;
                  end
                  OP_SLOPE: begin
                     slope_in = {div_quo_ff[RATE_W-2:0], 1'b0};
                     sum_in   = '0;
                     idx_in   = '0;
                     state_in = S_SUM;
                  end
                  OP_SPREAD: begin
                     share_q_in = div_quo_ff[RATE_W-1:0];
                     share_r_in = div_rem_ff[IDX_W-1:0];
                     idx_in     = '0;
                     state_in   = S_LOAD;
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end

         S_SUM: begin
            // Accumulate the ramp rates over all slices
            sum_in = sum_ff + SUM_W'(ramp_rate);
            if (idx_is_end) begin
               state_in = S_SHARE;
            end else begin
               idx_in = idx_ff + IDX_W'(1);
            end
         end

         S_SHARE: begin
            // Divide any positive shortfall among the slices
            div_quo_in = (TARGET_W'(sum_ff) < target_ff)
                       ? DIV_W'(target_ff - TARGET_W'(sum_ff)) : '0;
            div_den_in = DEN_W'(slices_ff);
            div_rem_in = '0;
            div_cnt_in = DIV_CNT_W'(DIV_W);
            op_in      = OP_SPREAD;
            state_in   = S_DIVIDE;
         end

         S_LOAD: begin
            // Build the item for the current slice
            out_idx_in  = idx_ff;
            out_rate_in = ramp_rate + share_q_ff + RATE_W'(idx_ff < share_r_ff);
            out_bad_in  = 1'b0;
            out_last_in = idx_is_end;
            state_in    = S_OUTPUT;
         end

         S_OUTPUT: begin
            // Hold the item until taken, then advance
            if (rsp_ready) begin
               if (out_last_ff) begin
                  state_in = S_IDLE;
               end else begin
                  idx_in   = idx_ff + IDX_W'(1);
                  state_in = S_LOAD;
               end
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         op_ff    <= OP_SLICES;
         pos_ff   <= '0;
      end else begin
         state_ff <= state_in;
         op_ff    <= op_in;
         pos_ff   <= pos_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      div_quo_ff  <= div_quo_in;
      div_rem_ff  <= div_rem_in;
      div_den_ff  <= div_den_in;
      div_cnt_ff  <= div_cnt_in;
      mag_ff      <= mag_in;
      neg_ff      <= neg_in;
      ms_ff       <= ms_in;
      slices_ff   <= slices_in;
      target_ff   <= target_in;
      slope_ff    <= slope_in;
      sum_ff      <= sum_in;
      share_q_ff  <= share_q_in;
      share_r_ff  <= share_r_in;
      idx_ff      <= idx_in;
      out_idx_ff  <= out_idx_in;
      out_rate_ff <= out_rate_in;
      out_bad_ff  <= out_bad_in;
      out_last_ff <= out_last_in;
   end

   // Ports
   assign req_ready        = (state_ff == S_IDLE);
   assign rsp_valid        = (state_ff == S_OUTPUT);
   assign rsp_slice_index  = out_idx_ff;
   assign rsp_step_rate    = out_rate_ff;
   assign rsp_direction    = neg_ff;
   assign rsp_target_steps = mag_ff;
   assign rsp_position     = pos_ff;
   assign rsp_bad_duration = out_bad_ff;
   assign rsp_last         = out_last_ff;

   // Checks
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("request and result channels active together");

   a_bad_single: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_bad_duration) |->
         (rsp_last && (rsp_step_rate == '0) && (rsp_slice_index == '0)))
      else $error("bad duration item is not a lone zero item");

   a_index_step: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && !rsp_last) |=> ##1
         (rsp_valid && (rsp_slice_index == $past(rsp_slice_index, 2) + IDX_W'(1))))
      else $error("slice index did not advance by one");

   a_pos_hold: assert property (@(posedge clock) disable iff (reset)
      !(req_valid && req_ready) |=> $stable(rsp_position))
      else $error("position moved without a command");

   a_div_rem: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIVIDE) |-> (div_rem_ff < div_den_ff))
      else $error("divider remainder not below divisor");

endmodule
